// ----- hw/rtl/dcbo_pkg.sv -----
package dcbo_pkg;

  localparam int MaxWidth = 1024;
  localparam int AddrW    = $clog2(MaxWidth);
  localparam int EffW     = AddrW + 1;

  localparam int DepthW = 16;
  localparam int LabelW = 21;
  localparam int ChanW  = 8;
  localparam int FwW    = 11;
  localparam int FhW    = 12;
  localparam int RowW   = 12;
  localparam int CfgW   = 12;
  localparam int RampW  = 10;

  localparam logic [FwW-1:0] WidthReset  = 11'd640;
  localparam logic [FhW-1:0] HeightReset = 12'd480;

  localparam logic [11:0] DepthClamp = 12'd2970;
  localparam logic [11:0] SegOne     = 12'd990;
  localparam logic [11:0] SegTwo     = 12'd1980;

  localparam logic [LabelW-1:0] LabelInvalid = 21'h1FFF9C;

  // v*17/66 == (v*270096) >> 20, exact for v <= 990
  localparam int RampMul   = 270096;
  localparam int RampShift = 20;
  localparam int RampProdW = 29;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic emit;
    logic check;
    logic frame_end;
  } stage_t;

  typedef struct packed {
    logic [ChanW-1:0] chan0;
    logic [ChanW-1:0] chan1;
    logic [ChanW-1:0] chan2;
    logic             frame_end;
  } pix_t;

  function automatic logic [ChanW-1:0] ramp(input logic [RampW-1:0] v);
    logic [RampProdW-1:0] p;
    p = RampProdW'(v) * RampProdW'(RampMul);
    return p[RampShift +: ChanW];
  endfunction

endpackage

// ----- hw/rtl/dcbo_if.sv -----
interface dcbo_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [dcbo_pkg::DepthW-1:0]         depth_mm;
  logic signed [dcbo_pkg::LabelW-1:0]  segment_label;

  modport source (output valid, command, depth_mm, segment_label, input ready);
  modport sink   (input valid, command, depth_mm, segment_label, output ready);
endinterface

interface dcbo_out_if;
  logic                        valid;
  logic                        ready;
  logic [dcbo_pkg::ChanW-1:0]  chan0;
  logic [dcbo_pkg::ChanW-1:0]  chan1;
  logic [dcbo_pkg::ChanW-1:0]  chan2;
  logic                        frame_end;

  modport source (output valid, chan0, chan1, chan2, frame_end, input ready);
  modport sink   (input valid, chan0, chan1, chan2, frame_end, output ready);
endinterface

// ----- hw/rtl/dcbo_line_store.sv -----
module dcbo_line_store (
  input  logic                         clk,
  input  logic                         we,
  input  logic [dcbo_pkg::AddrW-1:0]   waddr,
  input  logic [dcbo_pkg::LabelW-1:0]  wlabel,
  input  logic [dcbo_pkg::DepthW-1:0]  wdepth,
  input  logic                         re,
  input  logic [dcbo_pkg::AddrW-1:0]   addr_a,
  input  logic [dcbo_pkg::AddrW-1:0]   addr_b,
  output logic [dcbo_pkg::LabelW-1:0]  label_a,
  output logic [dcbo_pkg::DepthW-1:0]  depth_a,
  output logic [dcbo_pkg::LabelW-1:0]  label_b
);

  logic [dcbo_pkg::LabelW-1:0] label_mem [dcbo_pkg::MaxWidth];
  logic [dcbo_pkg::DepthW-1:0] depth_mem [dcbo_pkg::MaxWidth];

  logic [dcbo_pkg::LabelW-1:0] label_a_r;
  logic [dcbo_pkg::DepthW-1:0] depth_a_r;
  logic [dcbo_pkg::LabelW-1:0] label_b_r;

  // read-before-write: same-cycle read of waddr returns the previous row
  always_ff @(posedge clk) begin
    if (re) begin
      label_a_r <= label_mem[addr_a];
      depth_a_r <= depth_mem[addr_a];
      label_b_r <= label_mem[addr_b];
    end
    if (we) begin
      label_mem[waddr] <= wlabel;
      depth_mem[waddr] <= wdepth;
    end
  end

  assign label_a = label_a_r;
  assign depth_a = depth_a_r;
  assign label_b = label_b_r;

endmodule

// ----- hw/rtl/dcbo_seq.sv -----
module dcbo_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [dcbo_pkg::CfgW-1:0]    cfg_data,
  input  logic                         accept,
  input  logic                         command,
  output logic [dcbo_pkg::AddrW-1:0]   addr_a,
  output logic [dcbo_pkg::AddrW-1:0]   addr_b,
  output logic                         store_we,
  output logic [dcbo_pkg::AddrW-1:0]   store_addr,
  output dcbo_pkg::stage_t             info
);

  logic [dcbo_pkg::FwW-1:0]   frame_width_r,  frame_width_nxt;
  logic [dcbo_pkg::FhW-1:0]   frame_height_r, frame_height_nxt;
  logic [dcbo_pkg::AddrW-1:0] col_r,   col_nxt;
  logic [dcbo_pkg::RowW-1:0]  row_r,   row_nxt;
  logic [dcbo_pkg::EffW-1:0]  drain_r, drain_nxt;

  logic [dcbo_pkg::EffW-1:0]  w;
  logic [dcbo_pkg::FhW-1:0]   h;
  logic [dcbo_pkg::EffW-1:0]  col_inc;
  logic [dcbo_pkg::EffW-1:0]  drain_inc;
  logic [dcbo_pkg::RowW-1:0]  row_inc;
  logic                       act_pix;
  logic                       act_flush;

  always_comb begin
    if (32'(frame_width_r) > dcbo_pkg::MaxWidth) begin
      w = dcbo_pkg::EffW'(dcbo_pkg::MaxWidth);
    end else if (frame_width_r < 11'd2) begin
      w = dcbo_pkg::EffW'(2);
    end else begin
      w = dcbo_pkg::EffW'(frame_width_r);
    end
    h = (frame_height_r < 12'd2) ? 12'd2 : frame_height_r;

    col_inc   = {1'b0, col_r} + dcbo_pkg::EffW'(1);
    drain_inc = drain_r + dcbo_pkg::EffW'(1);
    row_inc   = row_r + 12'd1;

    act_pix   = !command && (row_r < h) && ({1'b0, col_r} < w);
    act_flush = command && (row_r >= h) && (drain_r < w);

    info.emit      = (act_pix && (row_r != '0)) || act_flush;
    info.check     = act_pix && (col_inc < w);
    info.frame_end = act_flush && (drain_inc >= w);

    addr_a     = command ? drain_r[dcbo_pkg::AddrW-1:0] : col_r;
    addr_b     = col_inc[dcbo_pkg::AddrW-1:0];
    store_we   = accept && act_pix;
    store_addr = col_r;

    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    drain_nxt        = drain_r;

    if (cfg_we) begin
      case (dcbo_pkg::cfg_idx_t'(cfg_index))
        dcbo_pkg::CFG_FRAME_WIDTH:  frame_width_nxt  = cfg_data[dcbo_pkg::FwW-1:0];
        dcbo_pkg::CFG_FRAME_HEIGHT: frame_height_nxt = cfg_data[dcbo_pkg::FhW-1:0];
        default: ;
      endcase
      col_nxt   = '0;
      row_nxt   = '0;
      drain_nxt = '0;
    end else if (accept && act_pix) begin
      if (col_inc >= w) begin
        col_nxt   = '0;
        row_nxt   = row_inc;
        drain_nxt = '0;
      end else begin
        col_nxt = col_inc[dcbo_pkg::AddrW-1:0];
      end
    end else if (accept && act_flush) begin
      if (drain_inc >= w) begin
        col_nxt   = '0;
        row_nxt   = '0;
        drain_nxt = '0;
      end else begin
        drain_nxt = drain_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= dcbo_pkg::WidthReset;
      frame_height_r <= dcbo_pkg::HeightReset;
      col_r          <= '0;
      row_r          <= '0;
      drain_r        <= '0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
      drain_r        <= drain_nxt;
    end
  end

endmodule

// ----- hw/rtl/dcbo_shade.sv -----
module dcbo_shade (
  input  dcbo_pkg::stage_t             info,
  input  logic [dcbo_pkg::DepthW-1:0]  up_depth,
  input  logic [dcbo_pkg::LabelW-1:0]  up_label,
  input  logic [dcbo_pkg::LabelW-1:0]  right_label,
  input  logic [dcbo_pkg::LabelW-1:0]  cur_label,
  output dcbo_pkg::pix_t               pix
);

  logic [11:0]                d;
  logic [11:0]                rise_w;
  logic [11:0]                fall_w;
  logic [dcbo_pkg::ChanW-1:0] rise_c;
  logic [dcbo_pkg::ChanW-1:0] fall_c;
  logic                       seg0;
  logic                       seg1;
  logic                       edge_hit;

  always_comb begin
    d = (up_depth > 16'(dcbo_pkg::DepthClamp)) ? dcbo_pkg::DepthClamp : up_depth[11:0];
    seg0 = d < dcbo_pkg::SegOne;
    seg1 = !seg0 && (d < dcbo_pkg::SegTwo);

    if (seg0) begin
      rise_w = d;
      fall_w = '0;
    end else if (seg1) begin
      rise_w = d - dcbo_pkg::SegOne;
      fall_w = dcbo_pkg::SegTwo - d;
    end else begin
      rise_w = d - dcbo_pkg::SegTwo;
      fall_w = dcbo_pkg::DepthClamp - d;
    end
    rise_c = dcbo_pkg::ramp(rise_w[dcbo_pkg::RampW-1:0]);
    fall_c = dcbo_pkg::ramp(fall_w[dcbo_pkg::RampW-1:0]);

    pix.frame_end = info.frame_end;
    if (seg0) begin
      pix.chan0 = rise_c;
      pix.chan1 = '0;
      pix.chan2 = '0;
    end else if (seg1) begin
      pix.chan0 = fall_c;
      pix.chan1 = rise_c;
      pix.chan2 = '0;
    end else begin
      pix.chan0 = '0;
      pix.chan1 = fall_c;
      pix.chan2 = rise_c;
    end

    edge_hit = (up_label != cur_label) || (up_label != right_label) ||
               (up_label == dcbo_pkg::LabelInvalid);
    if (info.check && edge_hit) begin
      pix.chan0 = '1;
      pix.chan1 = '1;
      pix.chan2 = '1;
    end else if (info.check && (up_depth == '0)) begin
      pix.chan0 = '0;
      pix.chan1 = '0;
      pix.chan2 = '0;
    end
  end

endmodule

// ----- hw/rtl/depth_colormap_boundary_overlay_core.sv -----
// Streams raster pixels (command, depth_mm, segment_label) at one beat per clock
// while the output is not stalled, and returns each pixel one row late as a depth
// color ramp with white segment boundaries; the first row of a frame returns
// nothing, and after the last row, flush beats drain it one pixel per beat, the
// final one flagged frame_end. A beat passes the registered line-store read, then
// the output register. The rate is set by the two-read, one-write line store that
// is read and written in the same cycle. A config write restarts the frame; line
// stores hold their contents and need no clearing.
module depth_colormap_boundary_overlay_core (
  input  logic                       clk,
  input  logic                       rst_n,
  dcbo_in_if.sink                    in_bus,
  dcbo_out_if.source                 out_bus,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [dcbo_pkg::CfgW-1:0]  cfg_data
);

  logic                        in_fire;
  logic                        in_ready;
  logic [dcbo_pkg::AddrW-1:0]  addr_a;
  logic [dcbo_pkg::AddrW-1:0]  addr_b;
  logic                        store_we;
  logic [dcbo_pkg::AddrW-1:0]  store_addr;
  dcbo_pkg::stage_t            info;
  logic [dcbo_pkg::LabelW-1:0] in_label;
  logic [dcbo_pkg::LabelW-1:0] up_label;
  logic [dcbo_pkg::DepthW-1:0] up_depth;
  logic [dcbo_pkg::LabelW-1:0] right_label;
  dcbo_pkg::pix_t              shade_pix;

  logic                        s1_valid_r, s1_valid_nxt;
  dcbo_pkg::stage_t            s1_info_r;
  logic [dcbo_pkg::LabelW-1:0] s1_label_r;
  logic                        s1_go;
  logic                        out_load;
  logic                        out_valid_r, out_valid_nxt;
  dcbo_pkg::pix_t              out_pix_r;

  assign in_label = dcbo_pkg::LabelW'(in_bus.segment_label);
  assign out_load = !out_valid_r || out_bus.ready;
  assign s1_go    = s1_valid_r && (!s1_info_r.emit || out_load);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_bus.valid && in_ready;

  dcbo_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (in_fire),
    .command    (in_bus.command),
    .addr_a     (addr_a),
    .addr_b     (addr_b),
    .store_we   (store_we),
    .store_addr (store_addr),
    .info       (info)
  );

  dcbo_line_store u_store (
    .clk     (clk),
    .we      (store_we),
    .waddr   (store_addr),
    .wlabel  (in_label),
    .wdepth  (in_bus.depth_mm),
    .re      (in_fire),
    .addr_a  (addr_a),
    .addr_b  (addr_b),
    .label_a (up_label),
    .depth_a (up_depth),
    .label_b (right_label)
  );

  dcbo_shade u_shade (
    .info        (s1_info_r),
    .up_depth    (up_depth),
    .up_label    (up_label),
    .right_label (right_label),
    .cur_label   (s1_label_r),
    .pix         (shade_pix)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = s1_valid_r && s1_info_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_info_r  <= info;
      s1_label_r <= in_label;
    end
    if (out_load) begin
      out_pix_r <= shade_pix;
    end
  end

  assign in_bus.ready      = in_ready;
  assign out_bus.valid     = out_valid_r;
  assign out_bus.chan0     = out_pix_r.chan0;
  assign out_bus.chan1     = out_pix_r.chan1;
  assign out_bus.chan2     = out_pix_r.chan2;
  assign out_bus.frame_end = out_pix_r.frame_end;

endmodule

// ----- hw/rtl/dcbo_checker.sv -----
module dcbo_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [dcbo_pkg::ChanW-1:0] out_chan0,
  input logic [dcbo_pkg::ChanW-1:0] out_chan1,
  input logic [dcbo_pkg::ChanW-1:0] out_chan2,
  input logic                       out_frame_end
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_chan0) && $stable(out_chan1) &&
      $stable(out_chan2) && $stable(out_frame_end))
    else $error("output beat changed under stall");

  // free output side never blocks input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output side free");

  // a new output beat is preceded by a matching accepted input beat
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("output beat without matching input beat");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind depth_colormap_boundary_overlay_core dcbo_checker u_dcbo_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_chan0     (out_bus.chan0),
  .out_chan1     (out_bus.chan1),
  .out_chan2     (out_bus.chan2),
  .out_frame_end (out_bus.frame_end)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int WatchLimit = 2000;
  localparam int DrainWait  = 6;
  localparam int ClampMm    = 2970;
  localparam int BandMm     = 990;
  localparam int LabelTop   = 1048575;
  localparam int WideCap    = 160;
  localparam int TallCap    = 160;
  localparam int RandItems  = 500;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [dcbo_pkg::CfgW-1:0] cfg_data;

  dcbo_in_if  in_bus ();
  dcbo_out_if out_bus ();

  depth_colormap_boundary_overlay_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // overlay predictor state
  logic [dcbo_pkg::FwW-1:0]    reg_w;
  logic [dcbo_pkg::FhW-1:0]    reg_h;
  logic [dcbo_pkg::LabelW-1:0] label_line [dcbo_pkg::MaxWidth];
  logic [dcbo_pkg::DepthW-1:0] depth_line [dcbo_pkg::MaxWidth];
  int col_q;
  int row_q;
  int drain_q;
  dcbo_pkg::pix_t expected_pixels [$];

  bit src_steady;
  bit snk_steady;
  int sink_hold;
  int mismatches;
  int items_sent;
  int idle_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int eff_w();
    if (reg_w < 2) return 2;
    if (reg_w > dcbo_pkg::MaxWidth) return dcbo_pkg::MaxWidth;
    return int'(reg_w);
  endfunction

  function automatic int eff_h();
    return (reg_h < 2) ? 2 : int'(reg_h);
  endfunction

  function automatic bit draining();
    return row_q >= eff_h();
  endfunction

  function automatic logic [dcbo_pkg::ChanW-1:0] scale(int v);
    return dcbo_pkg::ChanW'((v * 17) / 66);
  endfunction

  function automatic dcbo_pkg::pix_t ramp_color(logic [dcbo_pkg::DepthW-1:0] depth);
    dcbo_pkg::pix_t p;
    int d;
    p = '0;
    d = (depth > ClampMm) ? ClampMm : int'(depth);
    if (d < BandMm) begin
      p.chan0 = scale(d);
    end else if (d < 2 * BandMm) begin
      p.chan0 = scale(2 * BandMm - d);
      p.chan1 = scale(d - BandMm);
    end else begin
      p.chan1 = scale(ClampMm - d);
      p.chan2 = scale(d - 2 * BandMm);
    end
    return p;
  endfunction

  function automatic void restart_frame();
    col_q = 0;
    row_q = 0;
    drain_q = 0;
  endfunction

  function automatic void predict_overlay(bit cmd, logic [dcbo_pkg::DepthW-1:0] depth,
                                          logic [dcbo_pkg::LabelW-1:0] label);
    int w;
    int h;
    int x;
    dcbo_pkg::pix_t p;
    logic [dcbo_pkg::LabelW-1:0] up_l;
    logic [dcbo_pkg::DepthW-1:0] up_d;
    w = eff_w();
    h = eff_h();
    if (!cmd) begin
      x = col_q;
      if (row_q >= h || x >= w) return;
      if (row_q >= 1) begin
        up_l = label_line[x];
        up_d = depth_line[x];
        p = ramp_color(up_d);
        if (x + 1 < w) begin
          if (up_l != label || up_l != label_line[x+1] ||
              up_l == dcbo_pkg::LabelInvalid) begin
            p.chan0 = '1;
            p.chan1 = '1;
            p.chan2 = '1;
          end else if (up_d == 0) begin
            p = '0;
          end
        end
        expected_pixels.push_back(p);
      end
      label_line[x] = label;
      depth_line[x] = depth;
      col_q = x + 1;
      if (col_q >= w) begin
        col_q = 0;
        row_q++;
        if (row_q >= h) drain_q = 0;
      end
    end else begin
      if (row_q < h || drain_q >= w) return;
      p = ramp_color(depth_line[drain_q]);
      drain_q++;
      if (drain_q >= w) begin
        p.frame_end = 1'b1;
        restart_frame();
      end
      expected_pixels.push_back(p);
    end
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (src_steady || $urandom_range(0, 1) == 0) return 0;
    return stall_len();
  endfunction

  function automatic logic [dcbo_pkg::DepthW-1:0] rand_depth();
    int r;
    int edges [7] = '{989, 990, 1979, 1980, 2969, 2970, 2971};
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return dcbo_pkg::DepthW'($urandom_range(0, 65535));
    if (r == 2) return dcbo_pkg::DepthW'(edges[$urandom_range(0, 6)]);
    return dcbo_pkg::DepthW'($urandom_range(1, 3100));
  endfunction

  function automatic logic [dcbo_pkg::LabelW-1:0] rand_label();
    int v;
    v = int'($urandom_range(0, LabelTop + 100)) - 100;
    return dcbo_pkg::LabelW'(v);
  endfunction

  task automatic send_beat(bit cmd, logic [dcbo_pkg::DepthW-1:0] depth,
                           logic [dcbo_pkg::LabelW-1:0] label);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.command       <= cmd;
    in_bus.depth_mm      <= depth;
    in_bus.segment_label <= label;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    predict_overlay(cmd, depth, label);
    items_sent++;
  endtask

  // park the sender and let every pending pixel come out
  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_reg(dcbo_pkg::cfg_idx_t idx, logic [dcbo_pkg::CfgW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == dcbo_pkg::CFG_FRAME_WIDTH) reg_w = val[dcbo_pkg::FwW-1:0];
    else reg_h = val[dcbo_pkg::FhW-1:0];
    restart_frame();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(logic [dcbo_pkg::CfgW-1:0] w, logic [dcbo_pkg::CfgW-1:0] h);
    settle();
    write_reg(dcbo_pkg::CFG_FRAME_WIDTH, w);
    write_reg(dcbo_pkg::CFG_FRAME_HEIGHT, h);
  endtask

  // one frame of random pixels, with stray flushes and stray pixels mixed in;
  // a nonzero cap stops the frame after that many pixels
  task automatic stream_frame(bit cut_short, int cap);
    int w;
    int h;
    int n;
    int stop_at;
    int mode;
    int base;
    int split;
    int x;
    int y;
    logic [dcbo_pkg::LabelW-1:0] lab;
    w = eff_w();
    h = eff_h();
    mode = $urandom_range(0, 3);
    base = $urandom_range(0, LabelTop - 2);
    split = $urandom_range(1, w - 1);
    stop_at = cut_short ? $urandom_range(1, w * h - 1) : w * h;
    if (cap > 0 && cap < stop_at) stop_at = cap;
    n = 0;
    while (n < stop_at) begin
      if (n % 64 == 0) begin
        src_steady = ($urandom_range(0, 3) == 0);
        snk_steady = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 29) == 0) begin
        send_beat(1'b1, rand_depth(), rand_label());
      end else begin
        x = n % w;
        y = n / w;
        case (mode)
          0: lab = dcbo_pkg::LabelW'(base);
          1: lab = dcbo_pkg::LabelW'((x < split) ? base : base + 1);
          2: lab = dcbo_pkg::LabelW'((y < h / 2) ? base : base + 2);
          default: lab = dcbo_pkg::LabelW'(base + $urandom_range(0, 1));
        endcase
        if ($urandom_range(0, 39) == 0) lab = dcbo_pkg::LabelInvalid;
        else if ($urandom_range(0, 39) == 0) lab = rand_label();
        send_beat(1'b0, rand_depth(), lab);
        n++;
      end
      if ($urandom_range(0, 199) == 0) settle();
    end
    if (stop_at < w * h) return;
    while (draining()) begin
      if ($urandom_range(0, 9) == 0) send_beat(1'b0, rand_depth(), rand_label());
      else send_beat(1'b1, rand_depth(), rand_label());
    end
  endtask

  task automatic test_directed();
    int dd [12] = '{0, 989, 990, 1979,
                    1980, 2970, 2971, 65535,
                    989, 990, 1980, 2971};
    int ll [12] = '{5, 5, -100, -100,
                    5, 5, -100, -100,
                    6, 5, -100, LabelTop};
    src_steady = 1'b1;
    snk_steady = 1'b1;
    set_frame(dcbo_pkg::CfgW'(4), dcbo_pkg::CfgW'(3));
    send_beat(1'b1, dcbo_pkg::DepthW'(1234), dcbo_pkg::LabelW'(0));
    for (int i = 0; i < 12; i++) begin
      send_beat(1'b0, dcbo_pkg::DepthW'(dd[i]), dcbo_pkg::LabelW'(ll[i]));
    end
    send_beat(1'b0, dcbo_pkg::DepthW'(100), dcbo_pkg::LabelW'(5));
    for (int i = 0; i < 4; i++) send_beat(1'b1, dcbo_pkg::DepthW'(0), dcbo_pkg::LabelW'(0));
  endtask

  task automatic test_clamped_small();
    set_frame(dcbo_pkg::CfgW'(1), dcbo_pkg::CfgW'(0));
    stream_frame(1'b0, 0);
    set_frame(dcbo_pkg::CfgW'(2), dcbo_pkg::CfgW'(2));
    stream_frame(1'b0, 0);
  endtask

  task automatic test_widest_frame();
    set_frame(dcbo_pkg::CfgW'(12'hFFF), dcbo_pkg::CfgW'(1));
    stream_frame(1'b0, WideCap);
  endtask

  task automatic test_tallest_frame();
    set_frame(dcbo_pkg::CfgW'(0), dcbo_pkg::CfgW'(4095));
    stream_frame(1'b0, TallCap);
  endtask

  task automatic test_random_frames(int count);
    int stop;
    int w;
    int h;
    stop = items_sent + count;
    while (items_sent < stop) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 64) : $urandom_range(2, 9);
      if ($urandom_range(0, 15) == 0) w = $urandom_range(0, 1);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
      set_frame(dcbo_pkg::CfgW'(w), dcbo_pkg::CfgW'(h));
      stream_frame($urandom_range(0, 9) == 0, 0);
    end
  endtask

  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_bus.ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      out_bus.ready <= 1'b1;
      if (!snk_steady && $urandom_range(0, 3) == 0) sink_hold = stall_len();
    end
  end

  always @(posedge clk) begin
    dcbo_pkg::pix_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected beat: got %0d/%0d/%0d end=%0b",
                   out_bus.chan0, out_bus.chan1, out_bus.chan2, out_bus.frame_end);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_bus.chan0 !== want.chan0 || out_bus.chan1 !== want.chan1 ||
            out_bus.chan2 !== want.chan2 || out_bus.frame_end !== want.frame_end) begin
          if (mismatches < 10)
            $display("pixel mismatch: exp %0d/%0d/%0d end=%0b got %0d/%0d/%0d end=%0b",
                     want.chan0, want.chan1, want.chan2, want.frame_end,
                     out_bus.chan0, out_bus.chan1, out_bus.chan2, out_bus.frame_end);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("[depth_colormap_boundary_overlay_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = dcbo_pkg::CFG_FRAME_WIDTH;
    cfg_data             = '0;
    in_bus.valid         = 1'b0;
    in_bus.command       = 1'b0;
    in_bus.depth_mm      = '0;
    in_bus.segment_label = '0;
    out_bus.ready        = 1'b0;
    src_steady           = 1'b0;
    snk_steady           = 1'b0;
    sink_hold            = 0;
    mismatches           = 0;
    items_sent           = 0;
    idle_cycles          = 0;
    reg_w                = dcbo_pkg::WidthReset;
    reg_h                = dcbo_pkg::HeightReset;
    restart_frame();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_clamped_small();
    test_random_frames(RandItems);
    test_widest_frame();
    test_tallest_frame();

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[depth_colormap_boundary_overlay_core] OK");
    end else begin
      $display("[depth_colormap_boundary_overlay_core] ERROR");
    end
    $finish;
  end

endmodule
